>>> rtl/aqd_pkg.sv
package aqd_pkg;

	typedef struct packed {
		logic        func;
		logic [31:0] value;
	} item_t;

	typedef struct packed {
		logic [31:0] result;
		logic        saturated;
	} result_t;

	// configuration register indexes
	localparam logic [2:0] REG_IN_SCALE       = 3'd0;
	localparam logic [2:0] REG_IN_ZERO_POINT  = 3'd1;
	localparam logic [2:0] REG_IN_TYPE        = 3'd2;
	localparam logic [2:0] REG_OUT_SCALE      = 3'd3;
	localparam logic [2:0] REG_OUT_ZERO_POINT = 3'd4;
	localparam logic [2:0] REG_OUT_TYPE       = 3'd5;

	localparam logic [1:0] TYPE_UINT8 = 2'd0;
	localparam logic [1:0] TYPE_INT8  = 2'd1;

	localparam logic FUNC_QUANT   = 1'b0;
	localparam logic FUNC_DEQUANT = 1'b1;

	localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
	localparam logic [31:0] FP_QNAN    = 32'hFFC0_0000;
	localparam logic [31:0] FP_QUIET   = 32'h0040_0000;

	localparam logic signed [10:0] U8_MIN = 11'sd0;
	localparam logic signed [10:0] U8_MAX = 11'sd255;
	localparam logic signed [10:0] I8_MIN = -11'sd128;
	localparam logic signed [10:0] I8_MAX = 11'sd127;

	// quotient: 24 significand bits and one guard bit
	localparam int DIV_STAGES = 5;
	localparam int DIV_STEPS  = 5;
	localparam int DIV_BITS   = DIV_STAGES * DIV_STEPS;
	localparam int DIV_REM_W  = 26;

	typedef struct packed {
		logic        signed [9:0] exp;
		logic        [23:0]       mant;
	} norm_t;

	// sideband that travels alongside the divider
	typedef struct packed {
		logic              func;
		logic              bypass;
		logic [31:0]       value;
		logic              qsat;
		logic              qzero;
		logic              qsign;
		logic signed [9:0] qexp;
	} tag_t;

	function automatic logic [4:0] lzc24(input logic [23:0] a);
		logic [4:0] n;
		logic       found;
		n = 5'd24;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && a[i]) begin
				n = 5'(23 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc33(input logic [32:0] a);
		logic [5:0] n;
		logic       found;
		n = 6'd33;
		found = 1'b0;
		for (int i = 32; i >= 0; i--) begin
			if (!found && a[i]) begin
				n = 6'(32 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// significand with leading one at bit 23, value = mant * 2^(exp-23)
	function automatic norm_t fp_norm(input logic [31:0] f);
		norm_t      o;
		logic [4:0] lz;
		lz = lzc24({1'b0, f[22:0]});
		if (f[30:23] == 8'd0) begin
			o.mant = {1'b0, f[22:0]} << lz;
			o.exp  = -10'sd126 - $signed({5'd0, lz});
		end else begin
			o.mant = {1'b1, f[22:0]};
			o.exp  = $signed({2'b00, f[30:23]}) - 10'sd127;
		end
		return o;
	endfunction

endpackage

>>> rtl/aqd_div.sv
module aqd_div import aqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  tag_t                 in_tag,
	input  logic [DIV_REM_W-1:0] in_rem,
	input  logic [23:0]          in_den,
	output logic                 out_vld,
	output tag_t                 out_tag,
	output logic [DIV_BITS-1:0]  out_quo,
	output logic                 out_sticky
);

	logic                 vld_s [DIV_STAGES];
	tag_t                 tag_s [DIV_STAGES];
	logic [DIV_REM_W-1:0] rem_s [DIV_STAGES];
	logic [23:0]          den_s [DIV_STAGES];
	logic [DIV_BITS-1:0]  quo_s [DIV_STAGES];

	genvar g;
	for (g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic                 vld_d;
		tag_t                 tag_d;
		logic [DIV_REM_W-1:0] rem_d;
		logic [23:0]          den_d;
		logic [DIV_BITS-1:0]  quo_d;
		logic [DIV_REM_W-1:0] rem_n;
		logic [DIV_BITS-1:0]  quo_n;

		if (g == 0) begin : g_first
			assign vld_d = in_vld;
			assign tag_d = in_tag;
			assign rem_d = in_rem;
			assign den_d = in_den;
			assign quo_d = '0;
		end else begin : g_next
			assign vld_d = vld_s[g-1];
			assign tag_d = tag_s[g-1];
			assign rem_d = rem_s[g-1];
			assign den_d = den_s[g-1];
			assign quo_d = quo_s[g-1];
		end

		// restoring division, DIV_STEPS quotient bits per stage
		always_comb begin : step
			logic [DIV_REM_W-1:0] r;
			logic [DIV_BITS-1:0]  q;
			r = rem_d;
			q = quo_d;
			for (int i = 0; i < DIV_STEPS; i++) begin
				if (r >= {2'b00, den_d}) begin
					q = {q[DIV_BITS-2:0], 1'b1};
					r = r - {2'b00, den_d};
				end else begin
					q = {q[DIV_BITS-2:0], 1'b0};
				end
				r = {r[DIV_REM_W-2:0], 1'b0};
			end
			rem_n = r;
			quo_n = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_d;
			end
		end

		always_ff @(posedge clk) begin
			tag_s[g] <= tag_d;
			rem_s[g] <= rem_n;
			den_s[g] <= den_d;
			quo_s[g] <= quo_n;
		end
	end

	assign out_vld    = vld_s[DIV_STAGES-1];
	assign out_tag    = tag_s[DIV_STAGES-1];
	assign out_quo    = quo_s[DIV_STAGES-1];
	assign out_sticky = rem_s[DIV_STAGES-1] != '0;

endmodule

>>> rtl/aqd_mul.sv
module aqd_mul import aqd_pkg::*; (
	input  logic        clk,
	input  logic [8:0]  mag,
	input  logic        ksign,
	input  logic [31:0] scale,
	output logic [31:0] prod
);

	logic [7:0]  se;
	logic [22:0] sm;
	logic        sign_d;
	logic        spc_d;
	logic [31:0] spc_val_d;

	logic               sign_s2, spc_s2;
	logic [31:0]        spc_val_s2;
	logic [32:0]        prod_s2;
	logic signed [9:0]  e0_s2;

	logic               sign_s3, spc_s3;
	logic [31:0]        spc_val_s3;
	logic [32:0]        norm_s3;
	logic signed [10:0] exp_s3;

	logic               sign_s4, spc_s4;
	logic [31:0]        spc_val_s4;
	logic [23:0]        sig_s4;
	logic               guard_s4, stk_s4;
	logic [8:0]         expf_s4;

	logic [31:0]        res_s5;
	logic [31:0]        res_s6;

	assign se     = scale[30:23];
	assign sm     = scale[22:0];
	assign sign_d = ksign ^ scale[31];

	always_comb begin
		spc_d     = 1'b1;
		spc_val_d = {sign_d, 31'd0};
		if (se == 8'hFF && sm != 23'd0) begin
			spc_val_d = scale | FP_QUIET;
		end else if (se == 8'hFF) begin
			spc_val_d = (mag == 9'd0) ? FP_QNAN : {sign_d, 8'hFF, 23'd0};
		end else if (mag == 9'd0 || scale[30:0] == 31'd0) begin
			spc_val_d = {sign_d, 31'd0};
		end else begin
			spc_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2    <= sign_d;
		spc_s2     <= spc_d;
		spc_val_s2 <= spc_val_d;
		prod_s2    <= 33'(mag) * 33'({se != 8'd0, sm});
		e0_s2      <= (se == 8'd0) ? -10'sd149 : $signed({2'b00, se}) - 10'sd150;
	end

	// normalise so the leading one sits at bit 32
	always_ff @(posedge clk) begin : norm_stage
		logic [5:0] lz;
		lz = lzc33(prod_s2);
		sign_s3    <= sign_s2;
		spc_s3     <= spc_s2;
		spc_val_s3 <= spc_val_s2;
		norm_s3    <= prod_s2 << lz;
		exp_s3     <= 11'(e0_s2) + 11'sd32 - $signed({5'd0, lz});
	end

	// subnormal results shift right with sticky
	always_ff @(posedge clk) begin : denorm_stage
		logic [4:0]  sh;
		logic [32:0] shifted;
		logic        lost;
		sh      = 5'(-11'sd126 - exp_s3);
		shifted = norm_s3;
		lost    = 1'b0;
		if (exp_s3 < -11'sd126) begin
			shifted = norm_s3 >> sh;
			lost    = (norm_s3 & ((33'd1 << sh) - 33'd1)) != 33'd0;
			expf_s4 <= 9'd0;
		end else begin
			expf_s4 <= 9'(exp_s3 + 11'sd127);
		end
		sign_s4    <= sign_s3;
		spc_s4     <= spc_s3;
		spc_val_s4 <= spc_val_s3;
		sig_s4     <= shifted[32:9];
		guard_s4   <= shifted[8];
		stk_s4     <= (shifted[7:0] != 8'd0) | lost;
	end

	always_ff @(posedge clk) begin : round_stage
		logic [31:0] sum;
		logic        rnd;
		rnd = guard_s4 & (stk_s4 | sig_s4[0]);
		sum = {expf_s4, sig_s4[22:0]} + 32'(rnd);
		if (spc_s4) begin
			res_s5 <= spc_val_s4;
		end else if (sum[31:23] >= 9'd255) begin
			res_s5 <= {sign_s4, 8'hFF, 23'd0};
		end else begin
			res_s5 <= {sign_s4, sum[30:0]};
		end
	end

	always_ff @(posedge clk) begin
		res_s6 <= res_s5;
	end

	assign prod = res_s6;

endmodule

>>> rtl/affine_quantize_dequantize.sv
// channel   | ports                         | transfer
// ----------+-------------------------------+------------------------------------
// item in   | start, busy, item             | start high and busy low at clk rise
// result    | done, res                     | done high for one cycle per item
// config    | cfg_we, cfg_idx, cfg_wdata    | cfg_we high at clk rise
//
// one item per cycle; busy stays low, every start is taken
// eight register stages: stage 1, the five divider stages, stage 7 and stage 8; results reach res in order
// the quotient divider takes five bits per stage over five stages
// arst_n clears the valid bits and loads the register reset values
// results cannot be held off, so the pipeline never stalls
module affine_quantize_dequantize import aqd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] in_scale_q;
	logic [8:0]  in_zero_point_q;
	logic [1:0]  in_type_q;
	logic [31:0] out_scale_q;
	logic [8:0]  out_zero_point_q;
	logic [1:0]  out_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_scale_q       <= FP_ONE;
			in_zero_point_q  <= '0;
			in_type_q        <= TYPE_UINT8;
			out_scale_q      <= FP_ONE;
			out_zero_point_q <= '0;
			out_type_q       <= TYPE_UINT8;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IN_SCALE:       in_scale_q       <= cfg_wdata;
				REG_IN_ZERO_POINT:  in_zero_point_q  <= cfg_wdata[8:0];
				REG_IN_TYPE:        in_type_q        <= cfg_wdata[1:0];
				REG_OUT_SCALE:      out_scale_q      <= cfg_wdata;
				REG_OUT_ZERO_POINT: out_zero_point_q <= cfg_wdata[8:0];
				REG_OUT_TYPE:       out_type_q       <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// decode into stage 1
	logic                 accept;
	tag_t                 tag_d;
	logic [DIV_REM_W-1:0] rem_d;
	logic [23:0]          den_d;
	logic [8:0]           mag_d;
	logic                 ksign_d;

	assign accept = start & ~busy;

	always_comb begin
		norm_t             xn;
		norm_t             sn;
		logic              x_fin;
		logic              mant_lt;
		logic signed [9:0] code;
		logic signed [9:0] k;
		xn      = fp_norm(item.value);
		sn      = fp_norm(in_scale_q);
		x_fin   = item.value[30:23] != 8'hFF;
		mant_lt = xn.mant < sn.mant;

		tag_d.func   = item.func;
		tag_d.bypass = (item.func == FUNC_QUANT) ? in_type_q[1] : out_type_q[1];
		tag_d.value  = item.value;
		tag_d.qsign  = item.value[31] ^ in_scale_q[31];
		tag_d.qexp   = xn.exp - sn.exp - (mant_lt ? 10'sd1 : 10'sd0);
		tag_d.qsat   = 1'b0;
		tag_d.qzero  = 1'b0;
		if (!x_fin) begin
			tag_d.qsat = 1'b1;
		end else if (in_scale_q[30:0] == 31'h7F80_0000) begin
			// finite over infinite scale is zero
			tag_d.qzero = 1'b1;
		end else if (in_scale_q[30:23] == 8'hFF || in_scale_q[30:0] == 31'd0) begin
			tag_d.qsat = 1'b1;
		end else if (item.value[30:0] == 31'd0) begin
			tag_d.qzero = 1'b1;
		end

		rem_d = mant_lt ? {1'b0, xn.mant, 1'b0} : {2'b00, xn.mant};
		den_d = sn.mant;

		code = (out_type_q == TYPE_INT8) ? $signed({{2{item.value[7]}}, item.value[7:0]})
			: $signed({2'b00, item.value[7:0]});
		k       = code - $signed({out_zero_point_q[8], out_zero_point_q});
		ksign_d = k[9];
		mag_d   = k[9] ? 9'(-k) : k[8:0];
	end

	logic                 vld_s1;
	tag_t                 tag_s1;
	logic [DIV_REM_W-1:0] rem_s1;
	logic [23:0]          den_s1;
	logic [8:0]           mag_s1;
	logic                 ksign_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1   <= tag_d;
		rem_s1   <= rem_d;
		den_s1   <= den_d;
		mag_s1   <= mag_d;
		ksign_s1 <= ksign_d;
	end

	logic                vld_s6;
	tag_t                tag_s6;
	logic [DIV_BITS-1:0] quo_s6;
	logic                sticky_s6;
	logic [31:0]         mul_s6;

	aqd_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (vld_s1),
		.in_tag     (tag_s1),
		.in_rem     (rem_s1),
		.in_den     (den_s1),
		.out_vld    (vld_s6),
		.out_tag    (tag_s6),
		.out_quo    (quo_s6),
		.out_sticky (sticky_s6)
	);

	aqd_mul u_mul (
		.clk   (clk),
		.mag   (mag_s1),
		.ksign (ksign_s1),
		.scale (out_scale_q),
		.prod  (mul_s6)
	);

	// stage 7: round the quotient and take the nearest integer, half away from zero
	logic        vld_s7;
	logic        func_s7, bypass_s7;
	logic [31:0] value_s7;
	logic [31:0] mul_s7;
	logic        qflag_s7, big_s7, neg_s7;
	logic [9:0]  n_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin : round_stage
		logic [24:0]        sum;
		logic               rnd;
		logic [23:0]        m;
		logic signed [10:0] e;
		logic [4:0]         hs;
		logic [4:0]         sh;
		logic [24:0]        add;
		logic [24:0]        nw;
		rnd = quo_s6[0] & (sticky_s6 | quo_s6[1]);
		sum = {1'b0, quo_s6[24:1]} + 25'(rnd);
		if (sum[24]) begin
			m = 24'h80_0000;
			e = 11'(tag_s6.qexp) + 11'sd1;
		end else begin
			m = sum[23:0];
			e = 11'(tag_s6.qexp);
		end
		hs  = 5'(11'sd22 - e);
		sh  = 5'(11'sd23 - e);
		add = {1'b0, m} + (25'd1 << hs);
		nw  = add >> sh;

		func_s7   <= tag_s6.func;
		bypass_s7 <= tag_s6.bypass;
		value_s7  <= tag_s6.value;
		mul_s7    <= mul_s6;
		neg_s7    <= tag_s6.qsign;
		qflag_s7  <= tag_s6.qsat | (~tag_s6.qzero & (e >= 11'sd128));
		big_s7    <= ~tag_s6.qzero & (e >= 11'sd9);
		n_s7      <= (tag_s6.qzero || e <= -11'sd2) ? 10'd0 : nw[9:0];
	end

	// stage 8: add zero point, clamp, pick the result
	logic    vld_s8;
	result_t res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin : out_stage
		logic signed [10:0] lo;
		logic signed [10:0] hi;
		logic signed [10:0] nv;
		logic signed [10:0] r;
		logic signed [10:0] c;
		logic               sat;
		lo = (in_type_q == TYPE_INT8) ? I8_MIN : U8_MIN;
		hi = (in_type_q == TYPE_INT8) ? I8_MAX : U8_MAX;
		nv = $signed({1'b0, n_s7});
		if (neg_s7) begin
			nv = -nv;
		end
		r   = nv + $signed({{2{in_zero_point_q[8]}}, in_zero_point_q});
		c   = r;
		sat = 1'b0;
		if (big_s7) begin
			c   = neg_s7 ? lo : hi;
			sat = 1'b1;
		end else if (r > hi) begin
			c   = hi;
			sat = 1'b1;
		end else if (r < lo) begin
			c   = lo;
			sat = 1'b1;
		end

		if (bypass_s7) begin
			res_s8.result    <= value_s7;
			res_s8.saturated <= 1'b0;
		end else if (func_s7 == FUNC_DEQUANT) begin
			res_s8.result    <= mul_s7;
			res_s8.saturated <= 1'b0;
		end else if (qflag_s7) begin
			res_s8.result    <= 32'd0;
			res_s8.saturated <= 1'b1;
		end else begin
			res_s8.result    <= {{21{c[10]}}, c};
			res_s8.saturated <= sat;
		end
	end

	assign done = vld_s8;
	assign res  = res_s8;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import aqd_pkg::*;

	localparam int LATENCY     = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] wdata;
		logic        func;
		logic [31:0] value;
		logic        typed;
		result_t     exp;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     res;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	// local copy of the register file
	logic [31:0] q_scale;
	logic [8:0]  q_zp;
	logic [1:0]  q_type;
	logic [31:0] dq_scale;
	logic [8:0]  dq_zp;
	logic [1:0]  dq_type;

	result_t     pending_results[$];
	stim_row_t   directed[$];
	int          errors;
	int          cycles;
	int          n_quant;
	int          n_dequant;
	int          n_sat;
	int          n_checked;
	bit          idling_on;

	affine_quantize_dequantize u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic real fp_to_real(logic [31:0] f);
		real m;
		int  e;
		if (f[30:23] == 8'd0) begin
			m = real'(f[22:0]);
			e = -149;
		end else begin
			m = real'({1'b1, f[22:0]});
			e = int'(f[30:23]) - 150;
		end
		m = m * (2.0 ** e);
		if (f[31])
			m = -m;
		return m;
	endfunction

	// round a double to single precision, nearest even, with subnormals and overflow
	function automatic logic [31:0] real_to_fp(real r);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] keep;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] mag;
		int          e;
		int          drop;
		d = $realtobits(r);
		if (d[62:0] == 63'd0)
			return {d[63], 31'd0};
		e = int'(d[62:52]) - 1023 + 127;
		sig = {11'd0, 1'b1, d[51:0]};
		drop = 29 + ((e < 1) ? 1 - e : 0);
		if (drop >= 60) begin
			keep = 64'd0;
		end else begin
			keep = sig >> drop;
			rem = sig & ((64'd1 << drop) - 64'd1);
			half = 64'd1 << (drop - 1);
			if (rem > half || (rem == half && keep[0]))
				keep = keep + 64'd1;
		end
		// the implicit bit carries into the exponent field
		mag = keep + ((e >= 1) ? (64'(e - 1) << 23) : 64'd0);
		if (mag >= 64'h7F80_0000)
			mag = 64'h7F80_0000;
		return {d[63], mag[30:0]};
	endfunction

	function automatic bit is_finite(logic [31:0] f);
		return f[30:23] != 8'hFF;
	endfunction

	function automatic result_t quantize_elem(logic [31:0] v);
		result_t o;
		real     q;
		real     t;
		real     frac;
		real     r;
		real     lo;
		real     hi;
		logic [31:0] qb;
		o.result = 32'd0;
		o.saturated = 1'b0;
		lo = (q_type == TYPE_INT8) ? -128.0 : 0.0;
		hi = (q_type == TYPE_INT8) ? 127.0 : 255.0;
		if (!is_finite(v)) begin
			o.saturated = 1'b1;
			return o;
		end
		if (!is_finite(q_scale)) begin
			if (q_scale[22:0] != 23'd0) begin
				o.saturated = 1'b1;
				return o;
			end
			q = 0.0;
		end else if (q_scale[30:0] == 31'd0) begin
			o.saturated = 1'b1;
			return o;
		end else begin
			qb = real_to_fp(fp_to_real(v) / fp_to_real(q_scale));
			if (!is_finite(qb)) begin
				o.saturated = 1'b1;
				return o;
			end
			q = fp_to_real(qb);
		end
		// half away from zero, only below the integer-exact range
		if (q >= 8388608.0 || q <= -8388608.0) begin
			t = q;
		end else begin
			t = real'($rtoi(q));
			frac = q - t;
			if (frac >= 0.5)
				t = t + 1.0;
			else if (frac <= -0.5)
				t = t - 1.0;
		end
		r = fp_to_real(real_to_fp(t + real'($signed(q_zp))));
		if (r > hi) begin
			o.result = 32'($rtoi(hi));
			o.saturated = 1'b1;
		end else if (r < lo) begin
			o.result = 32'($rtoi(lo));
			o.saturated = 1'b1;
		end else begin
			o.result = 32'($rtoi(r));
		end
		return o;
	endfunction

	function automatic result_t dequantize_elem(logic [31:0] v);
		result_t o;
		int      code;
		int      diff;
		o.saturated = 1'b0;
		if (dq_type == TYPE_INT8)
			code = int'($signed(v[7:0]));
		else
			code = int'(v[7:0]);
		diff = code - int'($signed(dq_zp));
		if (!is_finite(dq_scale)) begin
			if (dq_scale[22:0] != 23'd0)
				o.result = dq_scale | FP_QUIET;
			else if (diff == 0)
				o.result = FP_QNAN;
			else
				o.result = {dq_scale[31] ^ (diff < 0), 31'h7F80_0000};
		end else begin
			o.result = real_to_fp(real'(diff) * fp_to_real(dq_scale));
		end
		return o;
	endfunction

	function automatic result_t predict_element(logic func, logic [31:0] v);
		result_t o;
		if (func == FUNC_QUANT) begin
			if (q_type[1]) begin
				o.result = v;
				o.saturated = 1'b0;
			end else begin
				o = quantize_elem(v);
			end
		end else begin
			if (dq_type[1]) begin
				o.result = v;
				o.saturated = 1'b0;
			end else begin
				o = dequantize_elem(v);
			end
		end
		return o;
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		start = 1'b0;
		wait (pending_results.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(posedge clk);
		case (idx)
			REG_IN_SCALE:       q_scale = data;
			REG_IN_ZERO_POINT:  q_zp = data[8:0];
			REG_IN_TYPE:        q_type = data[1:0];
			REG_OUT_SCALE:      dq_scale = data;
			REG_OUT_ZERO_POINT: dq_zp = data[8:0];
			REG_OUT_TYPE:       dq_type = data[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_item(logic func, logic [31:0] v, bit typed, result_t exp);
		int gap;
		if (idling_on && $urandom_range(0, 7) == 0) begin
			start = 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		item.func = func;
		item.value = v;
		do
			@(posedge clk);
		while (busy);
		pending_results.insert(pending_results.size(),
			typed ? exp : predict_element(func, v));
		if (func == FUNC_QUANT)
			n_quant++;
		else
			n_dequant++;
		@(negedge clk);
	endtask

	task automatic add_cfg(logic [2:0] idx, logic [31:0] data);
		stim_row_t r;
		r = '{ROW_CFG, idx, data, 1'b0, 32'd0, 1'b0, '0};
		directed.insert(directed.size(), r);
	endtask

	task automatic add_item(logic func, logic [31:0] v, bit typed, logic [31:0] er, logic es);
		stim_row_t r;
		r = '{ROW_ITEM, 3'd0, 32'd0, func, v, typed, '{er, es}};
		directed.insert(directed.size(), r);
	endtask

	function automatic logic [31:0] random_scale();
		logic [31:0] s;
		s = {1'b0, 8'($urandom_range(117, 132)), 23'($urandom)};
		if ($urandom_range(0, 9) == 0)
			s[31] = 1'b1;
		return s;
	endfunction

	function automatic logic [31:0] random_quant_value();
		int k;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 5))
					0: return 32'h7F80_0000;
					1: return 32'hFF80_0000;
					2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom) | 23'd1};
					3: return {$urandom_range(0, 1) == 1, 31'd0};
					4: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
					default: return {$urandom_range(0, 1) == 1, 31'h7F7F_FFFF};
				endcase
			end
			2, 3, 4, 5: begin
				// exact halves of the scale exercise the rounding ties
				k = $urandom_range(0, 1400) - 700;
				return real_to_fp(real'(k) * 0.5 * fp_to_real(q_scale));
			end
			default: begin
				k = $urandom_range(0, 1400) - 700;
				return real_to_fp((real'(k) + real'($urandom_range(0, 999)) / 1000.0)
					* fp_to_real(q_scale));
			end
		endcase
	endfunction

	task automatic random_phase(logic [31:0] qs, logic [8:0] qz, logic [1:0] qt,
		logic [31:0] ds, logic [8:0] dz, logic [1:0] dt, int count);
		logic        f;
		logic [31:0] v;
		write_reg(REG_IN_SCALE, qs);
		write_reg(REG_IN_ZERO_POINT, {{23{qz[8]}}, qz});
		write_reg(REG_IN_TYPE, {30'd0, qt});
		write_reg(REG_OUT_SCALE, ds);
		write_reg(REG_OUT_ZERO_POINT, {23'd0, dz});
		write_reg(REG_OUT_TYPE, {30'd0, dt});
		for (int i = 0; i < count; i++) begin
			f = $urandom_range(0, 1);
			v = (f == FUNC_QUANT) ? random_quant_value() : $urandom;
			send_item(f, v, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h sat %b", $realtime, res.result,
					res.saturated);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (res.saturated)
					n_sat++;
				if (res.result !== want.result) begin
					errors++;
					$display("%0t: result expected %h actual %h", $realtime, want.result,
						res.result);
				end
				if (res.saturated !== want.saturated) begin
					errors++;
					$display("%0t: saturated expected %b actual %b", $realtime,
						want.saturated, res.saturated);
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		n_quant = 0;
		n_dequant = 0;
		n_sat = 0;
		n_checked = 0;
		idling_on = 1'b1;
		q_scale = FP_ONE;
		q_zp = '0;
		q_type = TYPE_UINT8;
		dq_scale = FP_ONE;
		dq_zp = '0;
		dq_type = TYPE_UINT8;

		// values straight after reset: unit scale, zero point 0, uint8
		add_item(FUNC_QUANT, 32'h3F80_0000, 1, 32'd1, 0);
		add_item(FUNC_QUANT, 32'h3F00_0000, 1, 32'd1, 0);
		add_item(FUNC_QUANT, 32'h4020_0000, 1, 32'd3, 0);
		add_item(FUNC_QUANT, 32'hBF80_0000, 1, 32'd0, 1);
		add_item(FUNC_QUANT, 32'h437F_0000, 1, 32'd255, 0);
		add_item(FUNC_QUANT, 32'h4380_0000, 1, 32'd255, 1);
		add_item(FUNC_QUANT, 32'h7F80_0000, 1, 32'd0, 1);
		add_item(FUNC_QUANT, 32'h7FC0_0000, 1, 32'd0, 1);
		add_item(FUNC_QUANT, 32'h8000_0000, 1, 32'd0, 0);
		add_item(FUNC_DEQUANT, 32'h0000_00FF, 1, 32'h437F_0000, 0);
		add_item(FUNC_DEQUANT, 32'hFFFF_FF00, 1, 32'd0, 0);
		add_item(FUNC_DEQUANT, 32'h0000_0001, 1, FP_ONE, 0);
		add_cfg(REG_IN_TYPE, {30'd0, TYPE_INT8});
		add_item(FUNC_QUANT, 32'hC300_0000, 1, 32'hFFFF_FF80, 0);
		add_item(FUNC_QUANT, 32'hC348_0000, 1, 32'hFFFF_FF80, 1);
		add_item(FUNC_QUANT, 32'h42FE_0000, 1, 32'd127, 0);
		add_item(FUNC_QUANT, 32'hC020_0000, 1, 32'hFFFF_FFFD, 0);
		add_cfg(REG_OUT_TYPE, {30'd0, TYPE_INT8});
		add_item(FUNC_DEQUANT, 32'h0000_0080, 1, 32'hC300_0000, 0);
		add_item(FUNC_DEQUANT, 32'h0000_007F, 1, 32'h42FE_0000, 0);
		add_cfg(REG_IN_SCALE, 32'd0);
		add_item(FUNC_QUANT, 32'h3F80_0000, 1, 32'd0, 1);
		add_cfg(REG_IN_SCALE, 32'h7F80_0000);
		add_item(FUNC_QUANT, 32'h40A0_0000, 1, 32'd0, 0);
		add_cfg(REG_IN_TYPE, 32'd2);
		add_item(FUNC_QUANT, 32'hDEAD_BEEF, 1, 32'hDEAD_BEEF, 0);
		add_cfg(REG_OUT_TYPE, 32'd3);
		add_item(FUNC_DEQUANT, 32'h1234_5678, 1, 32'h1234_5678, 0);
		add_cfg(REG_IN_TYPE, {30'd0, TYPE_UINT8});
		add_cfg(REG_IN_SCALE, 32'h4000_0000);
		add_cfg(REG_IN_ZERO_POINT, 32'hFFFF_FF80);
		add_item(FUNC_QUANT, 32'h4120_0000, 0, '0, 0);
		add_cfg(REG_OUT_TYPE, {30'd0, TYPE_UINT8});
		add_cfg(REG_OUT_SCALE, 32'h3F00_0000);
		add_cfg(REG_OUT_ZERO_POINT, 32'd255);
		add_item(FUNC_DEQUANT, 32'h0000_0000, 0, '0, 0);
		add_item(FUNC_DEQUANT, 32'h0000_00FF, 0, '0, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].idx, directed[i].wdata);
			else
				send_item(directed[i].func, directed[i].value, directed[i].typed,
					directed[i].exp);
		end

		// each phase starts from an idle block, which is also the full drain pause
		random_phase(random_scale(), 9'd0, TYPE_UINT8, random_scale(), 9'd0,
			TYPE_UINT8, 120);
		random_phase(random_scale(), 9'h180, TYPE_INT8, random_scale(), 9'h0FF,
			TYPE_INT8, 120);
		random_phase(32'h0000_0001, 9'h0FF, TYPE_UINT8, 32'h7F7F_FFFF, 9'h180,
			TYPE_UINT8, 60);
		random_phase(32'h7F7F_FFFF, 9'h180, TYPE_INT8, 32'h0000_0001, 9'h0FF,
			TYPE_INT8, 60);
		random_phase(32'hFF80_0000, 9'd5, TYPE_INT8, 32'h7FC0_0001, 9'd3,
			TYPE_UINT8, 40);
		random_phase(32'h7FA0_0000, 9'd0, TYPE_UINT8, 32'hFF80_0000, 9'd0,
			TYPE_INT8, 40);
		random_phase($urandom, 9'($urandom), 2'd3, $urandom, 9'($urandom),
			2'd2, 40);
		random_phase(random_scale(), 9'($urandom_range(0, 511)), TYPE_INT8,
			random_scale(), 9'($urandom_range(0, 511)), TYPE_UINT8, 120);
		idling_on = 1'b0;
		random_phase(random_scale(), 9'($urandom_range(0, 511)), TYPE_UINT8,
			random_scale(), 9'($urandom_range(0, 511)), TYPE_INT8, 150);

		start = 1'b0;
		wait (pending_results.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);

		$display("covered %0d quantize and %0d dequantize transfers, %0d results checked",
			n_quant, n_dequant, n_checked);
		$display("%0d saturated results over nine register settings", n_sat);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
